[rtl/core/lfu_pkg.sv]
package lfu_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam int DATA_W = 32;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [DATA_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] stamp;
   } lfu_entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } lfu_cmd_type;

   typedef struct packed {
      logic scan_done;
   } lfu_sts_type;

endpackage

[rtl/core/lfu_ram.sv]
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lfu_ctrl.sv]
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  lfu_sts_type sts,
   output lfu_cmd_type cmd,
   output logic        busy,
   output logic        rsp_valid
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.load   = start && (state_ff == ST_IDLE);
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_SCAN) && sts.scan_done;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/lfu_dp.sv]
module lfu_dp
   import lfu_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  lfu_cmd_type       cmd,
   output lfu_sts_type       sts,
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data,
   input  logic              req_op,
   input  logic [DATA_W-1:0] req_key,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_hit,
   output logic [DATA_W-1:0] rsp_read_value
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(MAX_ENTRIES);
   localparam logic [CMP_W-1:0] MAX_CAP = CMP_W'(MAX_ENTRIES);

   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic                   op_ff, op_in;
   logic [DATA_W-1:0]      key_ff, key_in;
   logic [DATA_W-1:0]      value_ff, value_in;
   logic [CNT_W-1:0]       addr_ff, addr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       m_idx_ff, m_idx_in;
   logic [DATA_W-1:0]      m_value_ff, m_value_in;
   logic [DATA_W-1:0]      m_count_ff, m_count_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   best_found_ff, best_found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [DATA_W-1:0]      best_count_ff, best_count_in;
   logic [DATA_W-1:0]      best_stamp_ff, best_stamp_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic [DATA_W-1:0]      stamp_ff, stamp_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   lfu_entry_type          wr_entry;
   lfu_entry_type          rd_entry;
   logic [$bits(lfu_entry_type)-1:0] rd_raw;

   logic [CMP_W-1:0]       cap_x;
   logic [CMP_W-1:0]       cap_eff;
   logic [DATA_W-1:0]      count_inc;
   logic                   evict;
   logic [IDX_W-1:0]       slot;
   logic                   rd_v;

   lfu_ram #(
      .WIDTH ($bits(lfu_entry_type)),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_entry = lfu_entry_type'(rd_raw);
   assign sts.scan_done = (addr_ff == LAST_ADDR) && !rd_vld_ff;

   always_comb begin
      cap_x     = CMP_W'(cap_ff);
      cap_eff   = (cap_x > MAX_CAP) ? MAX_CAP : cap_x;
      count_inc = (m_count_ff == COUNT_MAX) ? m_count_ff : m_count_ff + 1'b1;
      evict     = CMP_W'(occ_ff) >= cap_eff;
      slot      = evict ? ((free_found_ff && (free_idx_ff < best_idx_ff)) ?
                           free_idx_ff : best_idx_ff) : free_idx_ff;
      rd_v      = valid_ff[rd_idx_ff];

      cap_in        = cap_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      addr_in       = addr_ff;
      rd_vld_in     = rd_vld_ff;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      m_idx_in      = m_idx_ff;
      m_value_in    = m_value_ff;
      m_count_in    = m_count_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_count_in = best_count_ff;
      best_stamp_in = best_stamp_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      stamp_in      = stamp_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_entry      = '0;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      if (cmd.load) begin
         op_in         = req_op;
         key_in        = req_key;
         value_in      = req_value;
         addr_in       = '0;
         rd_vld_in     = 1'b0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         best_found_in = 1'b0;
      end

      if (cmd.scan) begin
         // issue side: one table read per cycle
         if (addr_ff != LAST_ADDR) begin
            rd_vld_in = 1'b1;
            rd_idx_in = addr_ff[IDX_W-1:0];
            addr_in   = addr_ff + 1'b1;
         end else begin
            rd_vld_in = 1'b0;
         end
         // compare side: data read last cycle
         if (rd_vld_ff) begin
            if (rd_v && (rd_entry.key == key_ff) && !found_ff) begin
               found_in   = 1'b1;
               m_idx_in   = rd_idx_ff;
               m_value_in = rd_entry.value;
               m_count_in = rd_entry.count;
            end
            if (!rd_v && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = rd_idx_ff;
            end
            // strict compares keep the lowest index on a tie
            if (rd_v && (!best_found_ff || (rd_entry.count < best_count_ff) ||
                         ((rd_entry.count == best_count_ff) &&
                          (rd_entry.stamp < best_stamp_ff)))) begin
               best_found_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_count_in = rd_entry.count;
               best_stamp_in = rd_entry.stamp;
            end
         end
      end

      if (cmd.commit) begin
         rsp_hit_in   = 1'b0;
         rsp_value_in = '0;
         if (op_ff == OP_GET) begin
            if (found_ff) begin
               rsp_hit_in     = 1'b1;
               rsp_value_in   = m_value_ff;
               wr_en          = 1'b1;
               wr_addr        = m_idx_ff;
               wr_entry.key   = key_ff;
               wr_entry.value = m_value_ff;
               wr_entry.count = count_inc;
               wr_entry.stamp = stamp_ff;
               stamp_in       = stamp_ff + 1'b1;
            end
         end else if (cap_eff != '0) begin
            if (found_ff) begin
               wr_en          = 1'b1;
               wr_addr        = m_idx_ff;
               wr_entry.key   = key_ff;
               wr_entry.value = value_ff;
               wr_entry.count = count_inc;
               wr_entry.stamp = stamp_ff;
               stamp_in       = stamp_ff + 1'b1;
            end else begin
               if (evict) begin
                  valid_in[best_idx_ff] = 1'b0;
               end else begin
                  occ_in = occ_ff + 1'b1;
               end
               valid_in[slot] = 1'b1;
               wr_en          = 1'b1;
               wr_addr        = slot;
               wr_entry.key   = key_ff;
               wr_entry.value = value_ff;
               wr_entry.count = DATA_W'(1);
               wr_entry.stamp = stamp_ff;
               stamp_in       = stamp_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         valid_ff  <= '0;
         occ_ff    <= '0;
         stamp_ff  <= '0;
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         cap_ff    <= cap_in;
         valid_ff  <= valid_in;
         occ_ff    <= occ_in;
         stamp_ff  <= stamp_in;
         addr_ff   <= addr_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      m_idx_ff      <= m_idx_in;
      m_value_ff    <= m_value_in;
      m_count_ff    <= m_count_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_count_ff <= best_count_in;
      best_stamp_ff <= best_stamp_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

[rtl/core/lfu_cache_lru_tiebreak.sv]
// rsp_valid is registered from the commit that ends the scan.
// A new start is taken only while idle; the key search and the
//   (count, stamp) minimum share one pass over the entry RAM, one read a cycle.
// Reset (synchronous, active high) clears the valid bits, occupancy, the use
//   stamp counter and sets capacity to 16. The result has no backpressure.
module lfu_cache_lru_tiebreak
   import lfu_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_op,
   input  logic signed [DATA_W-1:0] req_key,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_read_value,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data
);

   lfu_cmd_type       cmd;
   lfu_sts_type       sts;
   logic [DATA_W-1:0] read_value;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lfu_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (read_value)
   );

   assign rsp_read_value = read_value;

`ifndef ASSERT_OFF
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid && !busy))
      else $error("commit did not produce one result");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(cmd.scan || cmd.commit))
      else $error("load while scanning");
`endif

endmodule
